@@ rtl/clipped_alpha_blend_blitter_core_defines.svh @@
// Assertion macros for the checker file.
`ifndef CLIPPED_ALPHA_BLEND_BLITTER_CORE_DEFINES_SVH
`define CLIPPED_ALPHA_BLEND_BLITTER_CORE_DEFINES_SVH

// Same-cycle implication, off while rst is high
`define CABB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while rst is high
`define CABB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cabb_pkg.sv @@
`timescale 1ns / 1ps
package cabb_pkg;

  // Field and datapath widths
  localparam int REG_BITS   = 12;
  localparam int COORD_BITS = 13;
  localparam int DIM_BITS   = 11;
  localparam int ADDR_BITS  = 24;
  localparam int PIX_BITS   = 32;
  localparam int CLIP_BITS  = 15;
  localparam int MAX_DRAW_DIM = 2000;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_DST_W = 2'd2;
  localparam logic [1:0] REG_DST_H = 2'd3;

  // Request codes, also used for the result kind
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef struct packed {
    logic [REG_BITS-1:0] src_w;
    logic [REG_BITS-1:0] src_h;
    logic [REG_BITS-1:0] dst_w;
    logic [REG_BITS-1:0] dst_h;
  } cfg_t;

  // One classified request, ready for the back end
  typedef struct packed {
    logic                 kind;
    logic                 ok;
    logic [DIM_BITS-1:0]  width;
    logic [DIM_BITS-1:0]  height;
    logic [ADDR_BITS-1:0] src_base;
    logic [ADDR_BITS-1:0] dst_base;
    logic [PIX_BITS-1:0]  pixel;
    logic                 we;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic nempty;
  } q_status_t;

endpackage

@@ rtl/clipped_alpha_blend_blitter_core.sv @@
`timescale 1ns / 1ps
// Channel  Handshake             Payload
// cfg      cfg_we                cfg_index, cfg_data
// in       in_valid / in_stall   cmd, dest_x/y, rect_x/y/w/h, src_pixel, dst_pixel
// out      out_valid / out_stall kind, draw_ok, draw_width/height, src/dst_addr,
//                                out_pixel, write_enable, last
//
// One request per cycle while in_stall is low; each result passes from its request
// through two clip/blend stages, address multiply into the queue, output register.
// A four-entry queue between front and back holds requests while out_stall is high;
// in_stall rises only when that queue is full and the last front stage is occupied.
// rst is synchronous: clears config registers, blit state and all valid flags.
module clipped_alpha_blend_blitter_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_index,
  input  logic [cabb_pkg::REG_BITS-1:0]          cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   cmd,
  input  logic signed [cabb_pkg::COORD_BITS-1:0] dest_x,
  input  logic signed [cabb_pkg::COORD_BITS-1:0] dest_y,
  input  logic signed [cabb_pkg::COORD_BITS-1:0] rect_x,
  input  logic signed [cabb_pkg::COORD_BITS-1:0] rect_y,
  input  logic signed [cabb_pkg::COORD_BITS-1:0] rect_w,
  input  logic signed [cabb_pkg::COORD_BITS-1:0] rect_h,
  input  logic [cabb_pkg::PIX_BITS-1:0]          src_pixel,
  input  logic [cabb_pkg::PIX_BITS-1:0]          dst_pixel,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   kind,
  output logic                                   draw_ok,
  output logic [cabb_pkg::DIM_BITS-1:0]          draw_width,
  output logic [cabb_pkg::DIM_BITS-1:0]          draw_height,
  output logic [cabb_pkg::ADDR_BITS-1:0]         src_addr,
  output logic [cabb_pkg::ADDR_BITS-1:0]         dst_addr,
  output logic [cabb_pkg::PIX_BITS-1:0]          out_pixel,
  output logic                                   write_enable,
  output logic                                   last
);
  import cabb_pkg::*;

  cfg_t      cfg;
  q_entry_t  push_data, pop_data;
  q_status_t q_stat;
  logic      q_push, q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_W: cfg.src_w <= cfg_data;
        REG_SRC_H: cfg.src_h <= cfg_data;
        REG_DST_W: cfg.dst_w <= cfg_data;
        REG_DST_H: cfg.dst_h <= cfg_data;
        default: ;
      endcase
    end
  end

  cabb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .dest_x    (dest_x),
    .dest_y    (dest_y),
    .rect_x    (rect_x),
    .rect_y    (rect_y),
    .rect_w    (rect_w),
    .rect_h    (rect_h),
    .src_pixel (src_pixel),
    .dst_pixel (dst_pixel),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  cabb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  cabb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_stat       (q_stat),
    .q_data       (pop_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .draw_ok      (draw_ok),
    .draw_width   (draw_width),
    .draw_height  (draw_height),
    .src_addr     (src_addr),
    .dst_addr     (dst_addr),
    .out_pixel    (out_pixel),
    .write_enable (write_enable),
    .last         (last)
  );

endmodule

@@ rtl/cabb_front.sv @@
`timescale 1ns / 1ps
module cabb_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cabb_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 cmd,
  input  logic signed [cabb_pkg::COORD_BITS-1:0] dest_x,
  input  logic signed [cabb_pkg::COORD_BITS-1:0] dest_y,
  input  logic signed [cabb_pkg::COORD_BITS-1:0] rect_x,
  input  logic signed [cabb_pkg::COORD_BITS-1:0] rect_y,
  input  logic signed [cabb_pkg::COORD_BITS-1:0] rect_w,
  input  logic signed [cabb_pkg::COORD_BITS-1:0] rect_h,
  input  logic [cabb_pkg::PIX_BITS-1:0]        src_pixel,
  input  logic [cabb_pkg::PIX_BITS-1:0]        dst_pixel,
  input  cabb_pkg::q_status_t                  q_stat,
  output logic                                 q_push,
  output cabb_pkg::q_entry_t                   q_data
);
  import cabb_pkg::*;

  localparam logic signed [CLIP_BITS-1:0] MAX_DIM_C = CLIP_BITS'(MAX_DRAW_DIM);

  // x / 255 for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  logic adv;

  // Stage 1 registers
  logic                  s1_valid;
  logic                  s1_cmd;
  logic                  s1_ok;
  logic [REG_BITS-1:0]   s1_rx, s1_ry, s1_rw, s1_rh;
  logic signed [COORD_BITS-1:0] s1_dx, s1_dy;
  logic [15:0]           s1_sum_r, s1_sum_g, s1_sum_b;
  logic [7:0]            s1_alpha;
  logic [PIX_BITS-1:0]   s1_src;

  // Stage 2 registers
  logic                  s2_valid;
  logic                  s2_cmd;
  logic                  s2_ok;
  logic [DIM_BITS-1:0]   s2_w, s2_h;
  logic [COORD_BITS-1:0] s2_sx, s2_sy;
  logic [REG_BITS-1:0]   s2_dx, s2_dy;
  logic [PIX_BITS-1:0]   s2_pix;
  logic                  s2_we;

  // Whole front moves unless the last stage is blocked by a full queue
  assign adv      = !(s2_valid && q_stat.full);
  assign in_stall = !adv;
  assign q_push   = s2_valid && !q_stat.full;

  // Stage 1: clip against the source surface, form blend products
  logic signed [CLIP_BITS-1:0] sw_e, sh_e, rx_a, ry_a, rw_a, rh_a;
  logic                        src_ok;
  logic [7:0]                  a_in, a_inv;
  logic [15:0]                 sum_r, sum_g, sum_b;

  always_comb begin
    sw_e = CLIP_BITS'(cfg.src_w);
    sh_e = CLIP_BITS'(cfg.src_h);
    rx_a = CLIP_BITS'(rect_x);
    ry_a = CLIP_BITS'(rect_y);
    rw_a = CLIP_BITS'(rect_w);
    rh_a = CLIP_BITS'(rect_h);
    if (rx_a[CLIP_BITS-1]) begin
      rw_a = rw_a + rx_a;
      rx_a = '0;
    end
    if (ry_a[CLIP_BITS-1]) begin
      rh_a = rh_a + ry_a;
      ry_a = '0;
    end
    if (rx_a + rw_a > sw_e) rw_a = sw_e - rx_a;
    if (ry_a + rh_a > sh_e) rh_a = sh_e - ry_a;
    src_ok = (cfg.src_w != '0) && (cfg.src_h != '0) &&
             (cfg.dst_w != '0) && (cfg.dst_h != '0) &&
             !rw_a[CLIP_BITS-1] && (rw_a != '0) &&
             !rh_a[CLIP_BITS-1] && (rh_a != '0);
  end

  assign a_in  = src_pixel[31:24];
  assign a_inv = 8'd255 - a_in;
  assign sum_r = 16'(src_pixel[23:16] * a_in) + 16'(dst_pixel[23:16] * a_inv);
  assign sum_g = 16'(src_pixel[15:8] * a_in) + 16'(dst_pixel[15:8] * a_inv);
  assign sum_b = 16'(src_pixel[7:0] * a_in) + 16'(dst_pixel[7:0] * a_inv);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd   <= cmd;
      s1_ok    <= src_ok;
      s1_rx    <= rx_a[REG_BITS-1:0];
      s1_ry    <= ry_a[REG_BITS-1:0];
      s1_rw    <= rw_a[REG_BITS-1:0];
      s1_rh    <= rh_a[REG_BITS-1:0];
      s1_dx    <= dest_x;
      s1_dy    <= dest_y;
      s1_sum_r <= sum_r;
      s1_sum_g <= sum_g;
      s1_sum_b <= sum_b;
      s1_alpha <= a_in;
      s1_src   <= src_pixel;
    end
  end

  // Stage 2: clip against the destination surface, finish the blend
  logic signed [CLIP_BITS-1:0] dw_e, dh_e, dx_b, dy_b, rw_b, rh_b, offx, offy;
  logic                        dst_ok;
  logic [COORD_BITS-1:0]       sx_b, sy_b;
  logic [PIX_BITS-1:0]         pix_b;
  logic                        we_b;

  always_comb begin
    dw_e = CLIP_BITS'(cfg.dst_w);
    dh_e = CLIP_BITS'(cfg.dst_h);
    dx_b = CLIP_BITS'(s1_dx);
    dy_b = CLIP_BITS'(s1_dy);
    rw_b = CLIP_BITS'(s1_rw);
    rh_b = CLIP_BITS'(s1_rh);
    offx = '0;
    offy = '0;
    if (dx_b[CLIP_BITS-1]) begin
      rw_b = rw_b + dx_b;
      offx = -dx_b;
      dx_b = '0;
    end
    if (dy_b[CLIP_BITS-1]) begin
      rh_b = rh_b + dy_b;
      offy = -dy_b;
      dy_b = '0;
    end
    if (dx_b + rw_b > dw_e) rw_b = dw_e - dx_b;
    if (dy_b + rh_b > dh_e) rh_b = dh_e - dy_b;
    dst_ok = s1_ok &&
             !rw_b[CLIP_BITS-1] && (rw_b != '0) && (rw_b <= MAX_DIM_C) &&
             !rh_b[CLIP_BITS-1] && (rh_b != '0) && (rh_b <= MAX_DIM_C);
    sx_b = COORD_BITS'(s1_rx) + offx[COORD_BITS-1:0];
    sy_b = COORD_BITS'(s1_ry) + offy[COORD_BITS-1:0];
  end

  // Transparent, opaque or blended
  always_comb begin
    if (s1_alpha == 8'd255) begin
      pix_b = s1_src;
      we_b  = 1'b1;
    end else if (s1_alpha == 8'd0) begin
      pix_b = '0;
      we_b  = 1'b0;
    end else begin
      pix_b = {8'h00, div255(s1_sum_r), div255(s1_sum_g), div255(s1_sum_b)};
      we_b  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cmd <= s1_cmd;
      s2_ok  <= dst_ok;
      s2_w   <= rw_b[DIM_BITS-1:0];
      s2_h   <= rh_b[DIM_BITS-1:0];
      s2_sx  <= sx_b;
      s2_sy  <= sy_b;
      s2_dx  <= dx_b[REG_BITS-1:0];
      s2_dy  <= dy_b[REG_BITS-1:0];
      s2_pix <= pix_b;
      s2_we  <= we_b;
    end
  end

  // Stage 3: start addresses, written into the queue
  logic [COORD_BITS+REG_BITS-1:0] src_prod;
  logic [2*REG_BITS-1:0]          dst_prod;

  assign src_prod = s2_sy * cfg.src_w;
  assign dst_prod = s2_dy * cfg.dst_w;

  always_comb begin
    q_data          = '0;
    q_data.kind     = s2_cmd;
    if (s2_cmd == CMD_PIXEL) begin
      q_data.pixel  = s2_pix;
      q_data.we     = s2_we;
    end else if (s2_ok) begin
      q_data.ok       = 1'b1;
      q_data.width    = s2_w;
      q_data.height   = s2_h;
      q_data.src_base = src_prod[ADDR_BITS-1:0] + ADDR_BITS'(s2_sx);
      q_data.dst_base = ADDR_BITS'(dst_prod) + ADDR_BITS'(s2_dx);
    end
  end

endmodule

@@ rtl/cabb_queue.sv @@
`timescale 1ns / 1ps
module cabb_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cabb_pkg::q_entry_t  push_data,
  input  logic                pop,
  output cabb_pkg::q_entry_t  pop_data,
  output cabb_pkg::q_status_t stat
);
  import cabb_pkg::*;

  q_entry_t             entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign stat.full   = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign stat.nempty = (count != '0);
  assign pop_data    = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

@@ rtl/cabb_back.sv @@
`timescale 1ns / 1ps
module cabb_back (
  input  logic                             clk,
  input  logic                             rst,
  input  cabb_pkg::cfg_t                   cfg,
  input  cabb_pkg::q_status_t              q_stat,
  input  cabb_pkg::q_entry_t               q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             kind,
  output logic                             draw_ok,
  output logic [cabb_pkg::DIM_BITS-1:0]    draw_width,
  output logic [cabb_pkg::DIM_BITS-1:0]    draw_height,
  output logic [cabb_pkg::ADDR_BITS-1:0]   src_addr,
  output logic [cabb_pkg::ADDR_BITS-1:0]   dst_addr,
  output logic [cabb_pkg::PIX_BITS-1:0]    out_pixel,
  output logic                             write_enable,
  output logic                             last
);
  import cabb_pkg::*;

  // Blit state
  logic                 active;
  logic [DIM_BITS-1:0]  reg_w, reg_h, col, row;
  logic [ADDR_BITS-1:0] src_rb, dst_rb;

  logic                 load;
  logic [DIM_BITS-1:0]  col_inc, row_inc;
  logic                 row_end, blit_end;

  // Take the next request when the output register is free or draining
  assign load  = q_stat.nempty && (!out_valid || !out_stall);
  assign q_pop = load;

  assign col_inc  = col + 1'b1;
  assign row_inc  = row + 1'b1;
  assign row_end  = (col_inc >= reg_w);
  assign blit_end = row_end && (row_inc >= reg_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // State update on each request taken
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      reg_w  <= '0;
      reg_h  <= '0;
      col    <= '0;
      row    <= '0;
      src_rb <= '0;
      dst_rb <= '0;
    end else if (load) begin
      if (q_data.kind == CMD_START) begin
        active <= q_data.ok;
        if (q_data.ok) begin
          reg_w  <= q_data.width;
          reg_h  <= q_data.height;
          col    <= '0;
          row    <= '0;
          src_rb <= q_data.src_base;
          dst_rb <= q_data.dst_base;
        end
      end else if (active) begin
        if (row_end) begin
          col    <= '0;
          row    <= blit_end ? '0 : row_inc;
          src_rb <= src_rb + ADDR_BITS'(cfg.src_w);
          dst_rb <= dst_rb + ADDR_BITS'(cfg.dst_w);
          if (blit_end) active <= 1'b0;
        end else begin
          col <= col_inc;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      kind         <= q_data.kind;
      draw_ok      <= 1'b0;
      draw_width   <= '0;
      draw_height  <= '0;
      src_addr     <= '0;
      dst_addr     <= '0;
      out_pixel    <= '0;
      write_enable <= 1'b0;
      last         <= 1'b0;
      if (q_data.kind == CMD_START) begin
        draw_ok     <= q_data.ok;
        draw_width  <= q_data.width;
        draw_height <= q_data.height;
        src_addr    <= q_data.src_base;
        dst_addr    <= q_data.dst_base;
      end else if (active) begin
        draw_ok      <= 1'b1;
        src_addr     <= src_rb + ADDR_BITS'(col);
        dst_addr     <= dst_rb + ADDR_BITS'(col);
        out_pixel    <= q_data.pixel;
        write_enable <= q_data.we;
        last         <= blit_end;
      end
    end
  end

endmodule

@@ rtl/cabb_checker.sv @@
`timescale 1ns / 1ps
`include "clipped_alpha_blend_blitter_core_defines.svh"
module cabb_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic                                   kind,
  input logic                                   draw_ok,
  input logic [cabb_pkg::DIM_BITS-1:0]          draw_width,
  input logic [cabb_pkg::DIM_BITS-1:0]          draw_height,
  input logic [cabb_pkg::ADDR_BITS-1:0]         src_addr,
  input logic [cabb_pkg::ADDR_BITS-1:0]         dst_addr,
  input logic [cabb_pkg::PIX_BITS-1:0]          out_pixel,
  input logic                                   write_enable,
  input logic                                   last
);
  import cabb_pkg::*;

  // A stalled result stays put
  `CABB_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(out_pixel) && $stable(dst_addr) && $stable(last), "result changed while stalled")

  // Rejected start reports nothing
  `CABB_ASSERT_NOW(a_reject_zero, out_valid && (kind == CMD_START) && !draw_ok, (draw_width == '0) && (draw_height == '0) && (src_addr == '0) && (dst_addr == '0), "rejected start carries data")

  // Accepted start has a region inside the size limit
  `CABB_ASSERT_NOW(a_start_dims, out_valid && (kind == CMD_START) && draw_ok, (draw_width != '0) && (draw_height != '0) && (draw_width <= DIM_BITS'(MAX_DRAW_DIM)) && (draw_height <= DIM_BITS'(MAX_DRAW_DIM)), "bad start region size")

  // No pixel data without a write
  `CABB_ASSERT_NOW(a_no_write_zero, out_valid && !write_enable, out_pixel == '0, "pixel data without write")

  // Writes and end marks only on pixels of an active blit
  `CABB_ASSERT_NOW(a_write_scope, out_valid && ((kind == CMD_START) || !draw_ok), !write_enable && !last, "write or last outside a blit")

endmodule

bind clipped_alpha_blend_blitter_core cabb_checker u_cabb_checker (.*);
